// ===== design/random_byte_to_charset_mapper_unit_macros.svh =====
// Assertion macros used by the mapper control module.
// In synthesis builds the macros expand to nothing.
`ifndef RANDOM_BYTE_TO_CHARSET_MAPPER_UNIT_MACROS_SVH
`define RANDOM_BYTE_TO_CHARSET_MAPPER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that cond holds in the same cycle as trig.
`define RBCM_ASSERT_IMPL(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("rbcm assertion failed");

// Checks that cond holds in the cycle after trig.
`define RBCM_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("rbcm assertion failed");

`else

`define RBCM_ASSERT_IMPL(label, clk, rst, trig, cond)
`define RBCM_ASSERT_NEXT(label, clk, rst, trig, cond)

`endif

`endif

// ===== design/rbcm_pkg.sv =====
package rbcm_pkg;

  // Default values of the top-level parameters.
  localparam int POOL_DEPTH_DEF    = 256;
  localparam int COUNTER_WIDTH_DEF = 16;

  // Fixed field widths.
  localparam int SIZE_W    = 9;
  localparam int LEN_W     = 16;
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASSWORD_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PASSWORD_COUNT  = 2'd2;

  // Command codes.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_RANDOM = 1'b1;

  // Character and range constants.
  localparam logic [CHAR_W-1:0] NL_CODE     = 8'd10;
  localparam logic [3:0]        NIBBLE_MASK = 4'hF;
  localparam logic [SIZE_W-1:0] NIB_SPAN    = 9'd16;
  localparam logic [SIZE_W-1:0] BYTE_SPAN   = 9'd256;

  // Reset values of the configuration registers.
  localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 9'd62;
  localparam logic [LEN_W-1:0]  PW_LENGTH_RST = 16'd16;
  localparam logic [LEN_W-1:0]  PW_COUNT_RST  = 16'd1;

  typedef struct packed {
    logic              command;
    logic [CHAR_W-1:0] pool_index;
    logic [CHAR_W-1:0] pool_char;
    logic [CHAR_W-1:0] random_byte;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_of_run;
    logic              all_done;
  } out_word_t;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [SIZE_W-1:0] rem;
  } div_rsp_t;

  // Pool memory ports.
  typedef struct packed {
    logic              we;
    logic [CHAR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } pool_wr_t;

  typedef struct packed {
    logic              re;
    logic [CHAR_W-1:0] addr;
  } pool_rd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_VALUE,
    ST_DIVIDE,
    ST_CHAR,
    ST_NEWLINE,
    ST_NEXT
  } state_t;

endpackage

// ===== design/random_byte_to_charset_mapper_unit.sv =====
// Channel   Direction  Handshake             Word
// in        input      in_valid / in_stall   rbcm_pkg::in_word_t
// out       output     out_valid / out_stall rbcm_pkg::out_word_t
// cfg       input      cfg_we (no wait)      cfg_index, cfg_data
//
// A load word writes the pool directly. A random byte examines each value in turn (the byte,
// or the high nibble and, unless the run has just finished, the low nibble); each kept value
// goes through the 9-step shared remainder unit, a pool read and an emit, then a newline if due.
// The first byte after reset or after a pool size write first finds the limit with that unit.
// Reset (rst, synchronous) clears the counters, the finished flag and the cached limit; the
// pool is undefined until loaded. A stalled output holds the sequencer in its emit state.
module random_byte_to_charset_mapper_unit #(
  parameter int POOL_DEPTH    = rbcm_pkg::POOL_DEPTH_DEF,
  parameter int COUNTER_WIDTH = rbcm_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rbcm_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rbcm_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [rbcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbcm_pkg::CFG_W-1:0]      cfg_data
);
  import rbcm_pkg::*;

  logic [SIZE_W-1:0] pool_entries;
  logic [LEN_W-1:0]  password_length;
  logic [LEN_W-1:0]  password_count;
  logic              limit_clear;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  pool_wr_t          pool_wr;
  pool_rd_t          pool_rd;
  logic [CHAR_W-1:0] pool_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_entries    <= POOL_SIZE_RST;
      password_length <= PW_LENGTH_RST;
      password_count  <= PW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POOL_SIZE:       pool_entries    <= cfg_data[SIZE_W-1:0];
        CFG_PASSWORD_LENGTH: password_length <= cfg_data[LEN_W-1:0];
        CFG_PASSWORD_COUNT:  password_count  <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A new pool size invalidates the cached rejection limit.
  assign limit_clear = cfg_we && (cfg_index == CFG_POOL_SIZE);

  rbcm_ctrl #(
    .POOL_DEPTH    (POOL_DEPTH),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .pool_entries    (pool_entries),
    .password_length (password_length),
    .password_count  (password_count),
    .limit_clear     (limit_clear),
    .div_req         (div_req),
    .div_rsp         (div_rsp),
    .pool_wr         (pool_wr),
    .pool_rd         (pool_rd),
    .pool_rdata      (pool_rdata)
  );

  rbcm_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rbcm_pool #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk   (clk),
    .wr    (pool_wr),
    .rd    (pool_rd),
    .rdata (pool_rdata)
  );

endmodule

// ===== design/rbcm_divider.sv =====
module rbcm_divider (
  input  logic              clk,
  input  logic              rst,
  input  rbcm_pkg::div_req_t req,
  output rbcm_pkg::div_rsp_t rsp
);
  import rbcm_pkg::*;

  localparam int CNT_W = $clog2(SIZE_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [SIZE_W-1:0] dvd;
  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] rem_next;
  logic [SIZE_W:0]   trial;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem, dvd[SIZE_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = SIZE_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[SIZE_W-1:0];
    end
  end

  // Control: busy for one cycle per dividend bit, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= CNT_W'(SIZE_W - 1);
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      dvd <= {dvd[SIZE_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

// ===== design/rbcm_pool.sv =====
module rbcm_pool #(
  parameter int POOL_DEPTH = rbcm_pkg::POOL_DEPTH_DEF
) (
  input  logic                          clk,
  input  rbcm_pkg::pool_wr_t            wr,
  input  rbcm_pkg::pool_rd_t            rd,
  output logic [rbcm_pkg::CHAR_W-1:0]   rdata
);
  import rbcm_pkg::*;

  localparam int IDX_W = $clog2(POOL_DEPTH);

  logic [CHAR_W-1:0] mem [POOL_DEPTH];

  // Character pool: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr[IDX_W-1:0]] <= wr.data;
    end
    if (rd.re) begin
      rdata <= mem[rd.addr[IDX_W-1:0]];
    end
  end

endmodule

// ===== design/rbcm_ctrl.sv =====
`include "random_byte_to_charset_mapper_unit_macros.svh"

module rbcm_ctrl #(
  parameter int POOL_DEPTH    = rbcm_pkg::POOL_DEPTH_DEF,
  parameter int COUNTER_WIDTH = rbcm_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rbcm_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rbcm_pkg::out_word_t           out_data,
  input  logic [rbcm_pkg::SIZE_W-1:0]   pool_entries,
  input  logic [rbcm_pkg::LEN_W-1:0]    password_length,
  input  logic [rbcm_pkg::LEN_W-1:0]    password_count,
  input  logic                          limit_clear,
  output rbcm_pkg::div_req_t            div_req,
  input  rbcm_pkg::div_rsp_t            div_rsp,
  output rbcm_pkg::pool_wr_t            pool_wr,
  output rbcm_pkg::pool_rd_t            pool_rd,
  input  logic [rbcm_pkg::CHAR_W-1:0]   pool_rdata
);
  import rbcm_pkg::*;

  localparam int CW = COUNTER_WIDTH;

  state_t state;
  state_t state_next;

  logic [CHAR_W-1:0] byte_r;
  logic              nib_r;
  logic              second_r;
  logic [SIZE_W-1:0] limit_r;
  logic              limit_ok;
  logic              more_r;
  logic              finished;
  logic [CW-1:0]     char_pos;
  logic [CW-1:0]     pw_made;

  logic [SIZE_W-1:0] psize_eff;
  logic              nib_now;
  logic [SIZE_W-1:0] span_now;
  logic [SIZE_W-1:0] span_r;
  logic [SIZE_W-1:0] cur_val;
  logic              cur_keep;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  cnt_eff;
  logic [CW-1:0]     cp_inc;
  logic [CW-1:0]     pm_inc;
  logic              nl;
  logic              fin_new;
  logic              more_now;
  logic              slot_free;
  logic              accept_rand;
  logic              load_char;
  logic              load_nl;

  // Effective pool size, length and count after the zero and depth clamps.
  always_comb begin
    if (pool_entries == '0) begin
      psize_eff = SIZE_W'(1);
    end else if (pool_entries > SIZE_W'(POOL_DEPTH)) begin
      psize_eff = SIZE_W'(POOL_DEPTH);
    end else begin
      psize_eff = pool_entries;
    end
    len_eff = (password_length == '0) ? LEN_W'(1) : password_length;
    cnt_eff = (password_count == '0) ? LEN_W'(1) : password_count;
  end

  assign nib_now  = (psize_eff <= NIB_SPAN);
  assign span_now = nib_now ? NIB_SPAN : BYTE_SPAN;
  assign span_r   = nib_r ? NIB_SPAN : BYTE_SPAN;

  // Candidate value: high nibble first, then low nibble, or the whole byte.
  always_comb begin
    if (!nib_r) begin
      cur_val = {1'b0, byte_r};
    end else if (second_r) begin
      cur_val = {5'b0, byte_r[3:0] & NIBBLE_MASK};
    end else begin
      cur_val = {5'b0, byte_r[7:4]};
    end
  end
  assign cur_keep = (cur_val < limit_r);

  // Counter look-ahead for the character about to be emitted.
  assign cp_inc   = char_pos + 1'b1;
  assign pm_inc   = pw_made + 1'b1;
  assign nl       = (32'(cp_inc) >= 32'(len_eff));
  assign fin_new  = nl && (32'(pm_inc) >= 32'(cnt_eff));
  assign more_now = nib_r && !second_r && !fin_new
                    && ({5'b0, byte_r[3:0]} < limit_r);

  assign slot_free   = !out_valid || !out_stall;
  assign accept_rand = (state == ST_IDLE) && in_valid
                       && (in_data.command == CMD_RANDOM) && !finished;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_rand) begin
          state_next = limit_ok ? ST_VALUE : ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        if (div_rsp.done) begin
          state_next = ST_VALUE;
        end
      end
      ST_VALUE: begin
        state_next = cur_keep ? ST_DIVIDE : ST_NEXT;
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_next = ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (slot_free) begin
          state_next = nl ? ST_NEWLINE : ST_NEXT;
        end
      end
      ST_NEWLINE: begin
        if (slot_free) begin
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (nib_r && !second_r && !finished) begin
          state_next = ST_VALUE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_stall         = (state != ST_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = cur_val;
    div_req.divisor  = psize_eff;
    pool_rd.re       = 1'b0;
    pool_rd.addr     = div_rsp.rem[CHAR_W-1:0];
    load_char        = 1'b0;
    load_nl          = 1'b0;
    case (state)
      ST_IDLE: begin
        div_req.start    = accept_rand && !limit_ok;
        div_req.dividend = span_now;
      end
      ST_VALUE: begin
        div_req.start = cur_keep;
      end
      ST_DIVIDE: begin
        pool_rd.re = div_rsp.done;
      end
      ST_CHAR: begin
        load_char = slot_free;
      end
      ST_NEWLINE: begin
        load_nl = slot_free;
      end
      default: begin
      end
    endcase
  end

  // Pool loads are taken straight from an accepted load word.
  always_comb begin
    pool_wr.we   = (state == ST_IDLE) && in_valid && (in_data.command == CMD_LOAD)
                   && ({1'b0, in_data.pool_index} < SIZE_W'(POOL_DEPTH));
    pool_wr.addr = in_data.pool_index;
    pool_wr.data = in_data.pool_char;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      limit_ok  <= 1'b0;
      finished  <= 1'b0;
      char_pos  <= '0;
      pw_made   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (limit_clear) begin
        limit_ok <= 1'b0;
      end else if ((state == ST_LIMIT) && div_rsp.done) begin
        limit_ok <= 1'b1;
      end
      if (load_char) begin
        char_pos <= nl ? '0 : cp_inc;
        if (nl) begin
          pw_made <= pm_inc;
        end
        if (fin_new) begin
          finished <= 1'b1;
        end
      end
      if (load_char || load_nl) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept_rand) begin
      byte_r   <= in_data.random_byte;
      nib_r    <= nib_now;
      second_r <= 1'b0;
    end else if ((state == ST_NEXT) && (state_next == ST_VALUE)) begin
      second_r <= 1'b1;
    end
    if ((state == ST_LIMIT) && div_rsp.done) begin
      limit_r <= span_r - div_rsp.rem;
    end
    if (load_char) begin
      more_r               <= more_now;
      out_data.out_char    <= pool_rdata;
      out_data.last_of_run <= !nl && !more_now;
      out_data.all_done    <= 1'b0;
    end else if (load_nl) begin
      out_data.out_char    <= NL_CODE;
      out_data.last_of_run <= !more_r;
      out_data.all_done    <= finished;
    end
  end

  `RBCM_ASSERT_IMPL(a_no_char_after_finish, clk, rst, load_char, !finished)
  `RBCM_ASSERT_IMPL(a_div_done_expected, clk, rst, div_rsp.done, (state == ST_LIMIT) || (state == ST_DIVIDE))
  `RBCM_ASSERT_IMPL(a_div_start_when_free, clk, rst, div_req.start, !div_rsp.busy)
  `RBCM_ASSERT_NEXT(a_final_newline, clk, rst, load_char && fin_new, finished && (state == ST_NEWLINE))

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rbcm_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_WORDS = 160;

  // One row of the directed plan: a register write or an input word, with the
  // results written out by hand where they are obvious.
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_val;
    in_word_t              word;
    bit                    typed;
    logic [2:0]            n_typed;
    out_word_t [1:0]       typed_res;
  } step_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // Mirror of the block state used to work out the expected characters.
  logic [CHAR_W-1:0]     pool_chars [256];
  logic [LEN_W-1:0]      chars_in_pw;
  logic [LEN_W-1:0]      pw_made;
  bit                    run_over;
  logic [SIZE_W-1:0]     set_pool_entries;
  logic [LEN_W-1:0]      set_pw_len;
  logic [LEN_W-1:0]      set_pw_cnt;

  out_word_t             batch[$];
  out_word_t             expected_chars[$];
  step_t                 plan[$];

  int                    mismatches;
  int                    stuck_cycles;
  bit                    calm;
  bit                    hold_off_req;

  random_byte_to_charset_mapper_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_word_t result_word(logic [CHAR_W-1:0] ch, logic last, logic done);
    result_word = '{out_char: ch, last_of_run: last, all_done: done};
  endfunction

  // A random-byte word; the load fields are ignored but still carry noise.
  function automatic in_word_t byte_word(logic [CHAR_W-1:0] b);
    byte_word = '{command: CMD_RANDOM, pool_index: 8'($urandom), pool_char: 8'($urandom),
                  random_byte: b};
  endfunction

  function automatic step_t cfg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_step = '0;
    cfg_step.is_cfg = 1'b1;
    cfg_step.reg_idx = idx;
    cfg_step.reg_val = val;
  endfunction

  function automatic step_t item_step(in_word_t w);
    item_step = '0;
    item_step.word = w;
  endfunction

  function automatic step_t typed_step(logic [CHAR_W-1:0] b, int n, out_word_t r0,
                                       out_word_t r1);
    typed_step = '0;
    typed_step.word = byte_word(b);
    typed_step.typed = 1'b1;
    typed_step.n_typed = 3'(n);
    typed_step.typed_res[0] = r0;
    typed_step.typed_res[1] = r1;
  endfunction

  // One candidate value: drop it past the limit, otherwise emit the pool entry
  // and close the password when it is long enough.
  function automatic void take_value(logic [SIZE_W-1:0] v, logic [SIZE_W-1:0] psize,
                                     logic [SIZE_W-1:0] limit);
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] cnt;
    len = (set_pw_len == '0) ? LEN_W'(1) : set_pw_len;
    cnt = (set_pw_cnt == '0) ? LEN_W'(1) : set_pw_cnt;
    if (run_over || v >= limit) return;
    batch.push_back(result_word(pool_chars[v % psize], 1'b0, 1'b0));
    chars_in_pw = chars_in_pw + 1'b1;
    if (chars_in_pw >= len) begin
      chars_in_pw = '0;
      pw_made = pw_made + 1'b1;
      if (pw_made >= cnt) run_over = 1'b1;
      batch.push_back(result_word(NL_CODE, 1'b0, run_over));
    end
  endfunction

  // Works out the results of one accepted word into batch.
  function automatic void predict_word(in_word_t w);
    logic [SIZE_W-1:0] psize;
    logic [SIZE_W-1:0] span;
    logic [SIZE_W-1:0] limit;
    batch.delete();
    if (w.command == CMD_LOAD) begin
      pool_chars[w.pool_index] = w.pool_char;
      return;
    end
    if (run_over) return;
    psize = (set_pool_entries == '0) ? SIZE_W'(1) : set_pool_entries;
    if (psize > POOL_DEPTH_DEF) psize = SIZE_W'(POOL_DEPTH_DEF);
    span = (psize <= NIB_SPAN) ? NIB_SPAN : BYTE_SPAN;
    limit = span - (span % psize);
    if (span == NIB_SPAN) begin
      take_value(SIZE_W'(w.random_byte[7:4]), psize, limit);
      take_value(SIZE_W'(w.random_byte & CHAR_W'(NIBBLE_MASK)), psize, limit);
    end else begin
      take_value(SIZE_W'(w.random_byte), psize, limit);
    end
    if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
  endfunction

  // Stops offering words until every expected character is back and the
  // block has had time to finish any word that gives nothing.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POOL_SIZE: begin
        set_pool_entries = val[SIZE_W-1:0];
      end
      CFG_PASSWORD_LENGTH: begin
        set_pw_len = val[LEN_W-1:0];
      end
      CFG_PASSWORD_COUNT: begin
        set_pw_cnt = val[LEN_W-1:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // Offers one word, possibly after a short gap, and predicts it once taken.
  task automatic send_word(in_word_t w, bit use_prediction);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    if (use_prediction) begin
      foreach (batch[k]) expected_chars.push_back(batch[k]);
    end
  endtask

  // Receiver: random stalls, a calm stretch, and one long hold-off.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < 14);
    end
  end

  // Each output word is checked against the oldest expected character.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected output word: char %0d last %0b done %0b",
                   out_data.out_char, out_data.last_of_run, out_data.all_done);
        end
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.out_char !== want.out_char || out_data.last_of_run !== want.last_of_run ||
            out_data.all_done !== want.all_done) begin
          if (mismatches < 10) begin
            $display("mismatch: expected char %0d last %0b done %0b, got char %0d last %0b done %0b",
                     want.out_char, want.last_of_run, want.all_done,
                     out_data.out_char, out_data.last_of_run, out_data.all_done);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("random_byte_to_charset_mapper_unit test failed");
      $finish;
    end
  end

  initial begin
    int sent;
    int phase_words;
    bit held;
    bit paused;
    logic [SIZE_W-1:0] psize_pick;
    logic [LEN_W-1:0] len_pick;

    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    mismatches = 0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    held = 1'b0;
    paused = 1'b0;
    sent = 0;
    chars_in_pw = '0;
    pw_made = '0;
    run_over = 1'b0;
    set_pool_entries = POOL_SIZE_RST;
    set_pw_len = PW_LENGTH_RST;
    set_pw_cnt = PW_COUNT_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Fill every pool entry so no read ever hits an unwritten one.
    for (int i = 0; i < POOL_DEPTH_DEF; i++) begin
      send_word('{command: CMD_LOAD, pool_index: 8'(i), pool_char: 8'(255 - i),
                  random_byte: 8'($urandom)}, 1'b1);
    end

    // Directed plan. Entry i holds 255 - i at this point.
    // Reset settings: 62 entries, byte mode, limit 248.
    plan.push_back(typed_step(8'h00, 1, result_word(8'd255, 1'b1, 1'b0), '0));
    plan.push_back(typed_step(8'hF7, 1, result_word(8'd194, 1'b1, 1'b0), '0));
    plan.push_back(typed_step(8'hF8, 0, '0, '0));
    plan.push_back(typed_step(8'hFF, 0, '0, '0));
    plan.push_back(cfg_step(CFG_PASSWORD_COUNT, 16'hFFFF));
    // Single entry pool: both nibbles pick entry zero.
    plan.push_back(cfg_step(CFG_POOL_SIZE, 16'd1));
    plan.push_back(typed_step(8'hFF, 2, result_word(8'd255, 1'b0, 1'b0),
                              result_word(8'd255, 1'b1, 1'b0)));
    // A zero pool size acts as one.
    plan.push_back(cfg_step(CFG_POOL_SIZE, 16'd0));
    plan.push_back(item_step(byte_word(8'h5A)));
    // Three entries: nibble 15 is rejected, on either half.
    plan.push_back(cfg_step(CFG_POOL_SIZE, 16'd3));
    plan.push_back(item_step(byte_word(8'hF0)));
    plan.push_back(item_step(byte_word(8'h0F)));
    plan.push_back(cfg_step(CFG_POOL_SIZE, 16'd16));
    plan.push_back(typed_step(8'hA5, 2, result_word(8'd245, 1'b0, 1'b0),
                              result_word(8'd250, 1'b1, 1'b0)));
    // Smallest byte-mode pool: limit 255.
    plan.push_back(cfg_step(CFG_POOL_SIZE, 16'd17));
    plan.push_back(item_step(byte_word(8'hFF)));
    plan.push_back(item_step(byte_word(8'hFE)));
    plan.push_back(cfg_step(CFG_POOL_SIZE, 16'd256));
    plan.push_back(item_step(byte_word(8'hFF)));
    // A size past the depth saturates.
    plan.push_back(cfg_step(CFG_POOL_SIZE, 16'd511));
    plan.push_back(item_step(byte_word(8'h80)));
    // Length one: the position is already past it, so a newline follows at once.
    plan.push_back(cfg_step(CFG_PASSWORD_LENGTH, 16'd1));
    plan.push_back(item_step(byte_word(8'h80)));
    // Two entries with length one give four results from one byte.
    plan.push_back(cfg_step(CFG_POOL_SIZE, 16'd2));
    plan.push_back(item_step(byte_word(8'h33)));
    plan.push_back(cfg_step(CFG_PASSWORD_LENGTH, 16'd0));
    plan.push_back(item_step(byte_word(8'hC1)));
    plan.push_back(item_step('{command: CMD_LOAD, pool_index: 8'd0, pool_char: 8'h7E,
                               random_byte: 8'h00}));
    plan.push_back(item_step(byte_word(8'h00)));
    plan.push_back(cfg_step(CFG_PASSWORD_LENGTH, 16'hFFFF));
    plan.push_back(item_step(byte_word(8'h6B)));
    plan.push_back(item_step(byte_word(8'h92)));
    // Shrinking the length mid-password closes it on the next character.
    plan.push_back(cfg_step(CFG_PASSWORD_LENGTH, 16'd3));
    plan.push_back(item_step(byte_word(8'h44)));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].word, !plan[i].typed);
        if (plan[i].typed) begin
          for (int k = 0; k < plan[i].n_typed; k++) expected_chars.push_back(plan[i].typed_res[k]);
        end
      end
    end

    // Random phases, each with fresh settings. The count stays well ahead of
    // the passwords made so the block keeps producing.
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(9))
        0: psize_pick = '0;
        1: psize_pick = SIZE_W'($urandom_range(257, 511));
        2, 3, 4, 5: psize_pick = SIZE_W'($urandom_range(1, 16));
        9: psize_pick = SIZE_W'(256);
        default: psize_pick = SIZE_W'($urandom_range(17, 256));
      endcase
      case ($urandom_range(9))
        0: len_pick = '0;
        1: len_pick = 16'hFFFF;
        2: len_pick = 16'd1;
        default: len_pick = LEN_W'($urandom_range(2, 12));
      endcase
      write_reg(CFG_POOL_SIZE, CFG_W'(psize_pick));
      write_reg(CFG_PASSWORD_LENGTH, len_pick);
      write_reg(CFG_PASSWORD_COUNT, CFG_W'($urandom_range(65535, int'(pw_made) + 200)));
      phase_words = $urandom_range(25, 60);
      for (int j = 0; j < phase_words && sent < RANDOM_WORDS; j++) begin
        calm = (sent >= 100 && sent < 140);
        if (!held && sent >= 40) begin
          held = 1'b1;
          hold_off_req = 1'b1;
        end
        if (!paused && sent >= 80) begin
          paused = 1'b1;
          drain();
        end
        if ($urandom_range(99) < 15) begin
          send_word('{command: CMD_LOAD, pool_index: 8'($urandom), pool_char: 8'($urandom),
                      random_byte: 8'($urandom)}, 1'b1);
        end else begin
          send_word(byte_word(8'($urandom)), 1'b1);
        end
        sent++;
      end
    end
    calm = 1'b0;

    // Finish the run: with length one and count zero the high nibble of the
    // next byte completes the last password and its low nibble is discarded.
    write_reg(CFG_POOL_SIZE, CFG_W'($urandom_range(1, 16)));
    write_reg(CFG_PASSWORD_LENGTH, 16'd1);
    write_reg(CFG_PASSWORD_COUNT, 16'd0);
    send_word(byte_word({4'h0, 4'($urandom)}), 1'b1);
    // Once finished, bytes are ignored and loads are still taken.
    for (int j = 0; j < 12; j++) begin
      if (j % 4 == 3) begin
        send_word('{command: CMD_LOAD, pool_index: 8'($urandom), pool_char: 8'($urandom),
                    random_byte: 8'($urandom)}, 1'b1);
      end else begin
        send_word(byte_word(8'($urandom)), 1'b1);
      end
    end
    drain();

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("random_byte_to_charset_mapper_unit test passed");
    end else begin
      $display("random_byte_to_charset_mapper_unit test failed");
    end
    $finish;
  end

endmodule
